>>> sv/mfd_pkg.sv
// shared constants for the mesh frame deframer
package mfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned KIND_W = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BADLEN = 2'd3;

	// configuration register indexes
	localparam logic CFG_HDR_FIRST  = 1'b0;
	localparam logic CFG_HDR_SECOND = 1'b1;

	// reset values of the header pair
	localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'hF1;
	localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'hDD;

	// ascii "OK"
	localparam logic [BYTE_W-1:0] ASCII_O = 8'h4F;
	localparam logic [BYTE_W-1:0] ASCII_K = 8'h4B;

	// shortest legal length byte: id and skip bytes only
	localparam logic [BYTE_W-1:0] MIN_LEN = 8'd4;

	// bytes swallowed after "OK"
	localparam logic [BYTE_W-1:0] ACK_TAIL = 8'd2;

endpackage

>>> sv/mesh_frame_deframer_top.sv
// receive byte stream deframer for a mesh radio module
//
// usage:
//   input channel (in_valid / in_stall / in_byte) carries one received byte per
//   transfer. output channel (out_valid / out_stall / kind, node_id, data_byte,
//   last_byte) carries zero or one result per input byte: acknowledge, payload
//   byte tagged with the node id, empty message, or bad length.
//   header_first / header_second are written through cfg_we / cfg_index /
//   cfg_wdata while the block is idle; they reset to 0xF1 / 0xDD.
// path: a byte is captured in the input stage; its result (if any) is then
//   written into the output register as soon as that register is free.
// throughput: one byte per cycle unless a result waits on a stalled output;
//   the per-byte state update is a single pass of compare and decrement
//   logic between the input stage and the output register.
// reset: arst_n low clears both stages and puts the deframer back to hunting
//   with no previous byte; the header pair returns to its reset values.
// stall: while out_stall holds a waiting result, a byte in the input stage that
//   has a result waits there and in_stall rises; nothing is dropped. a byte
//   that gives no result never needs the output register and moves on.
module mesh_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] node_id,
	output logic [7:0]  data_byte,
	output logic        last_byte
);
	import mfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ACK     = 3'd1,
		PH_LEN     = 3'd2,
		PH_ID      = 3'd3,
		PH_SKIP    = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_ERRSKIP = 3'd6
	} phase_t;

	// header pair registers
	logic [BYTE_W-1:0] hdr_first_q, hdr_second_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// deframer state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] prev_q, prev_d;     // last hunted byte
	logic [BYTE_W-1:0] rem_q, rem_d;       // bytes left in ack tail, payload or skip
	logic              pos_q, pos_d;       // have-previous flag / second-byte flag
	logic [ID_W-1:0]   id_q, id_d;

	// result of the current byte
	logic              res_v;
	logic [KIND_W-1:0] res_kind;
	logic [ID_W-1:0]   res_id;
	logic [BYTE_W-1:0] res_data;
	logic              res_last;

	logic              out_free;   // output register can take a new result
	logic              go_s1;      // input stage byte is processed this cycle
	logic [BYTE_W-1:0] rem_dec;

	// the output register frees up when empty or when its result is taken
	assign out_free = !out_valid || !out_stall;
	// a byte only waits when it has a result and the output is blocked
	assign go_s1    = valid_s1 && (out_free || !res_v);
	assign in_stall = valid_s1 && !go_s1;

	// header pair registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HDR_FIRST_RST;
			hdr_second_q <= HDR_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HDR_FIRST:  hdr_first_q  <= cfg_wdata;
				CFG_HDR_SECOND: hdr_second_q <= cfg_wdata;
				default:        hdr_first_q  <= hdr_first_q;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// per-byte state update and result
	always_comb begin
		phase_d  = phase_q;
		prev_d   = prev_q;
		rem_d    = rem_q;
		pos_d    = pos_q;
		id_d     = id_q;
		res_v    = 1'b0;
		res_kind = KIND_ACK;
		res_id   = '0;
		res_data = '0;
		res_last = 1'b0;
		rem_dec  = rem_q - 8'd1;

		unique case (phase_q)
			PH_ACK: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HUNT;
					pos_d   = 1'b0;
					res_v   = 1'b1;
				end
			end
			PH_LEN: begin
				if (byte_s1 < MIN_LEN) begin
					// bad length: flag it, then skip that many bytes
					if (byte_s1 == '0) begin
						phase_d = PH_HUNT;
						pos_d   = 1'b0;
					end else begin
						phase_d = PH_ERRSKIP;
						rem_d   = byte_s1;
					end
					res_v    = 1'b1;
					res_kind = KIND_BADLEN;
				end else begin
					rem_d   = byte_s1 - MIN_LEN;
					phase_d = PH_ID;
					pos_d   = 1'b0;
				end
			end
			PH_ID: begin
				if (!pos_q) begin
					id_d[ID_W-1:BYTE_W] = byte_s1;
					pos_d               = 1'b1;
				end else begin
					id_d[BYTE_W-1:0] = byte_s1;
					phase_d          = PH_SKIP;
					pos_d            = 1'b0;
				end
			end
			PH_SKIP: begin
				if (!pos_q) begin
					pos_d = 1'b1;
				end else if (rem_q == '0) begin
					// empty message reported on the second skipped byte
					phase_d  = PH_HUNT;
					pos_d    = 1'b0;
					res_v    = 1'b1;
					res_kind = KIND_EMPTY;
					res_id   = id_q;
				end else begin
					phase_d = PH_PAYLOAD;
					pos_d   = 1'b0;
				end
			end
			PH_PAYLOAD: begin
				rem_d    = rem_dec;
				res_v    = 1'b1;
				res_kind = KIND_DATA;
				res_id   = id_q;
				res_data = byte_s1;
				res_last = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_HUNT;
					pos_d   = 1'b0;
				end
			end
			PH_ERRSKIP: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HUNT;
					pos_d   = 1'b0;
				end
			end
			default: begin
				// hunting; the header pair wins over "OK"
				if (pos_q && prev_q == hdr_first_q && byte_s1 == hdr_second_q) begin
					phase_d = PH_LEN;
					pos_d   = 1'b0;
				end else if (pos_q && prev_q == ASCII_O && byte_s1 == ASCII_K) begin
					phase_d = PH_ACK;
					rem_d   = ACK_TAIL;
					pos_d   = 1'b0;
				end else begin
					phase_d = PH_HUNT;
					prev_d  = byte_s1;
					pos_d   = 1'b1;
				end
			end
		endcase
	end

	// deframer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prev_q  <= '0;
			rem_q   <= '0;
			pos_q   <= 1'b0;
			id_q    <= '0;
		end else if (go_s1) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			id_q    <= id_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= go_s1 && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go_s1 && res_v) begin
			kind      <= res_kind;
			node_id   <= res_id;
			data_byte <= res_data;
			last_byte <= res_last;
		end
	end

endmodule

>>> sv/mfd_checker.sv
// port-level checks for the mesh frame deframer, bound to the top level
module mfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [15:0] node_id,
	input logic [7:0]  data_byte,
	input logic        last_byte
);
	import mfd_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// only payload results carry a data byte
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
		else $error("data byte set on non-payload result");

	// the last mark belongs to payload results alone
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> kind == KIND_DATA)
		else $error("last mark on non-payload result");

	// acknowledge and bad length carry no node id
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACK || kind == KIND_BADLEN) |-> node_id == 16'd0)
		else $error("node id set on ack or bad length");

endmodule

bind mesh_frame_deframer_top mfd_checker u_mfd_checker (.*);
